[hw/rtl/mfb_pkg.sv]
package mfb_pkg;

	localparam int MAX_WIDTH   = 128;
	localparam int MAX_HEIGHT  = 64;
	localparam int FRAME_DEPTH = 1024;
	localparam int AW          = $clog2(FRAME_DEPTH);
	localparam int SZW         = AW + 1;
	localparam int PAW         = 18;

	localparam logic [1:0] OP_FILL  = 2'd0;
	localparam logic [1:0] OP_PIXEL = 2'd1;
	localparam logic [1:0] OP_LINE  = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_ORDER  = 2'd2;

	typedef struct packed {
		logic [7:0] width;
		logic [6:0] height;
		logic [1:0] order;
	} cfg_t;

	typedef struct packed {
		logic [1:0]     op;
		logic           bad;
		logic           color;
		logic [7:0]     xs;
		logic [7:0]     ys;
		logic           xneg;
		logic           yneg;
		logic [7:0]     ax;
		logic [7:0]     ay;
		logic [7:0]     dur;
		logic [9:0]     addr;
		logic [SZW-1:0] size;
	} cmd_t;

	typedef struct packed {
		logic status;
		logic [7:0] data;
	} res_t;

endpackage

[hw/rtl/mfb_ram.sv]
module mfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hw/rtl/mfb_front.sv]
module mfb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    operation,
	input  logic [7:0]    x_start,
	input  logic [7:0]    y_start,
	input  logic [7:0]    x_end,
	input  logic [7:0]    y_end,
	input  logic          pixel_color,
	input  logic [9:0]    byte_address,
	output mfb_pkg::cfg_t cfg,
	output mfb_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  logic          cmd_pop
);
	import mfb_pkg::*;

	cfg_t       cfg_q;
	cmd_t       q_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       c;
	logic [5:0] wbytes;
	logic [3:0] hbytes;
	logic [13:0] sz;
	logic [6:0] hd;
	logic       do_push;

	assign cfg       = cfg_q;
	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];
	assign do_push   = push && !full;
	assign hd        = cfg_data[6:0];

	always_comb begin
		c       = '0;
		c.op    = operation;
		c.color = pixel_color;
		c.xs    = x_start;
		c.ys    = y_start;
		c.addr  = byte_address;
		c.xneg  = (x_end < x_start);
		c.yneg  = (y_end < y_start);
		c.ax    = c.xneg ? x_start - x_end : x_end - x_start;
		c.ay    = c.yneg ? y_start - y_end : y_end - y_start;
		c.dur   = (c.ax > c.ay) ? c.ax : c.ay;
		wbytes  = 6'((9'(cfg_q.width) + 9'd7) >> 3);
		hbytes  = 4'((8'(cfg_q.height) + 8'd7) >> 3);
		if (!cfg_q.order[1]) begin
			sz = 14'(wbytes) * 14'(cfg_q.height);
		end else begin
			sz = 14'(hbytes) * 14'(cfg_q.width);
		end
		if (32'(sz) > FRAME_DEPTH) begin
			c.size = SZW'(FRAME_DEPTH);
		end else begin
			c.size = SZW'(sz);
		end
		case (operation)
			OP_PIXEL: c.bad = (x_start >= cfg_q.width) || (y_start >= 8'(cfg_q.height));
			OP_LINE:  c.bad = (x_start > cfg_q.width) || (x_end > cfg_q.width) ||
				(y_start > 8'(cfg_q.height)) || (y_end > 8'(cfg_q.height));
			OP_READ:  c.bad = (32'(byte_address) >= FRAME_DEPTH);
			default:  c.bad = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= 8'(MAX_WIDTH);
			cfg_q.height <= 7'(MAX_HEIGHT);
			cfg_q.order  <= 2'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH: begin
					if (cfg_data == 8'd0) cfg_q.width <= 8'd1;
					else if (32'(cfg_data) > MAX_WIDTH) cfg_q.width <= 8'(MAX_WIDTH);
					else cfg_q.width <= cfg_data;
				end
				REG_HEIGHT: begin
					if (hd == 7'd0) cfg_q.height <= 7'd1;
					else if (32'(hd) > MAX_HEIGHT) cfg_q.height <= 7'(MAX_HEIGHT);
					else cfg_q.height <= hd;
				end
				REG_ORDER: cfg_q.order <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (cmd_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) q_q[wp_q] <= c;
	end
endmodule

[hw/rtl/mfb_back.sv]
module mfb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  mfb_pkg::cfg_t cfg,
	input  mfb_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	output logic          empty,
	input  logic          pop,
	output logic          status,
	output logic [7:0]    read_data
);
	import mfb_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FILL = 3'd1;
	localparam logic [2:0] S_PRD  = 3'd2;
	localparam logic [2:0] S_PWR  = 3'd3;
	localparam logic [2:0] S_RA   = 3'd4;
	localparam logic [2:0] S_RRD  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]     st_q;
	cmd_t           cmd_q;
	logic [7:0]     px_q, py_q, i_q;
	logic [8:0]     accx_q, accy_q;
	logic [SZW-1:0] fcnt_q;
	res_t           res_q;
	res_t           oq_q [2];
	logic           owp_q, orp_q;
	logic [1:0]     ocnt_q;
	logic           ofull, opush;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [7:0]     ram_wdata, ram_rdata;

	logic [PAW-1:0] pa;
	logic           pok;
	logic [2:0]     sel;
	logic [7:0]     mask;
	logic [8:0]     sx, sy;
	logic           last;

	mfb_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign ofull     = (ocnt_q == 2'd2);
	assign empty     = (ocnt_q == 2'd0);
	assign status    = oq_q[orp_q].status;
	assign read_data = oq_q[orp_q].data;
	assign opush     = (st_q == S_DONE);
	assign cmd_pop   = (st_q == S_IDLE) && cmd_valid && !ofull;

	always_comb begin
		if (!cfg.order[1]) begin
			pa  = PAW'((PAW'(py_q) * PAW'(cfg.width) + PAW'(px_q)) >> 3);
			sel = px_q[2:0];
		end else begin
			pa  = PAW'(py_q >> 3) * PAW'(cfg.width) + PAW'(px_q);
			sel = py_q[2:0];
		end
		mask = cfg.order[0] ? (8'h01 << sel) : (8'h80 >> sel);
		pok  = (px_q < cfg.width) && (py_q < 8'(cfg.height)) &&
			(32'(pa) < FRAME_DEPTH);
		sx   = accx_q + 9'(cmd_q.ax);
		sy   = accy_q + 9'(cmd_q.ay);
		last = ((i_q + 8'd1) == cmd_q.dur);
		ram_we    = 1'b0;
		ram_waddr = pa[AW-1:0];
		ram_wdata = cmd_q.color ? (ram_rdata | mask) : (ram_rdata & ~mask);
		ram_raddr = pa[AW-1:0];
		case (st_q)
			S_FILL: begin
				ram_we    = (fcnt_q < cmd_q.size);
				ram_waddr = fcnt_q[AW-1:0];
				ram_wdata = cmd_q.color ? 8'hFF : 8'h00;
			end
			S_PWR: ram_we = 1'b1;
			S_RA:  ram_raddr = AW'(cmd_q.addr);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (cmd_pop) begin
						cmd_q  <= cmd;
						res_q  <= '{status: cmd.bad, data: 8'd0};
						px_q   <= cmd.xs;
						py_q   <= cmd.ys;
						i_q    <= 8'd0;
						accx_q <= 9'd0;
						accy_q <= 9'd0;
						fcnt_q <= '0;
						case (cmd.op)
							OP_FILL: st_q <= S_FILL;
							OP_PIXEL: begin
								st_q <= cmd.bad ? S_DONE : S_PRD;
							end
							OP_LINE: begin
								st_q <= (cmd.bad || cmd.dur == 8'd0) ? S_DONE : S_PRD;
							end
							default: begin
								st_q <= cmd.bad ? S_DONE : S_RA;
							end
						endcase
					end
				end
				S_FILL: begin
					fcnt_q <= fcnt_q + SZW'(1);
					if (fcnt_q >= cmd_q.size) st_q <= S_DONE;
				end
				S_PRD, S_PWR: begin
					if (st_q == S_PRD && pok) begin
						st_q <= S_PWR;
					end else if (cmd_q.op == OP_PIXEL) begin
						res_q.status <= !pok;
						st_q <= S_DONE;
					end else if (last) begin
						st_q <= S_DONE;
					end else begin
						st_q <= S_PRD;
						i_q  <= i_q + 8'd1;
						if (sx >= 9'(cmd_q.dur)) begin
							accx_q <= sx - 9'(cmd_q.dur);
							px_q   <= cmd_q.xneg ? px_q - 8'd1 : px_q + 8'd1;
						end else begin
							accx_q <= sx;
						end
						if (sy >= 9'(cmd_q.dur)) begin
							accy_q <= sy - 9'(cmd_q.dur);
							py_q   <= cmd_q.yneg ? py_q - 8'd1 : py_q + 8'd1;
						end else begin
							accy_q <= sy;
						end
					end
				end
				S_RA: st_q <= S_RRD;
				S_RRD: begin
					res_q.data <= ram_rdata;
					st_q <= S_DONE;
				end
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (opush) owp_q <= ~owp_q;
			if (pop && !empty) orp_q <= ~orp_q;
			ocnt_q <= ocnt_q + 2'(opush) - 2'(pop && !empty);
		end
	end

	always_ff @(posedge clk) begin
		if (opush) oq_q[owp_q] <= res_q;
	end
endmodule

[hw/rtl/mono_framebuffer_pixel_line_engine_top.sv]
// channel   handshake        payload
// command   push / full      operation x_start y_start x_end y_end pixel_color byte_address
// result    empty / pop      status read_data
// config    cfg_we           cfg_index cfg_data
//
// one command at a time in the back end; two-deep queues on the command and result sides
// fill writes each byte of padded size; set pixel: read, write; read byte: address, read
// line: ram read-modify-write per drawn point, read only if skipped; bad: no ram use
// arst_n resets control, sets config to 128x64 order 0; frame is undefined until written
// full stays high while two commands wait; a full result queue holds the back end before start
module mono_framebuffer_pixel_line_engine_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [1:0] operation,
	input  logic [7:0] x_start,
	input  logic [7:0] y_start,
	input  logic [7:0] x_end,
	input  logic [7:0] y_end,
	input  logic       pixel_color,
	input  logic [9:0] byte_address,
	output logic       empty,
	input  logic       pop,
	output logic       status,
	output logic [7:0] read_data
);
	import mfb_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	logic cmd_valid, cmd_pop;

	mfb_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .push(push), .full(full), .operation(operation),
		.x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
		.pixel_color(pixel_color), .byte_address(byte_address), .cfg(cfg),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
	);

	mfb_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop), .empty(empty), .pop(pop), .status(status),
		.read_data(read_data)
	);
endmodule
